FILE: hw/rtl/gcm_pkg.sv
// Shared types, constants and functions for the AES-GCM encryptor.
// Holds the S-box, the AES round, the GHASH step and the command record.
// No dependencies.
`default_nettype none
package gcm_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW    = 64;
  localparam int unsigned BLK_W     = 128;
  localparam int unsigned CNT_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW     = 3'd5;

  localparam logic [CNT_W-1:0] FULL_BLOCK_BYTES = 5'd16;
  localparam logic [31:0]      J0_COUNTER       = 32'd1;
  localparam logic [7:0]       GF_POLY          = 8'hE1;

  typedef enum logic [3:0] {
    ST_WAIT_KEY,
    ST_HASH_KEY,
    ST_IDLE,
    ST_CTR_AES,
    ST_CT_OUT,
    ST_GH_DATA,
    ST_LEN_PREP,
    ST_GH_LEN,
    ST_TAG_AES,
    ST_TAG_OUT
  } back_state_e;

  typedef struct packed {
    logic             do_text;
    logic             do_aad;
    logic             last;
    logic [CNT_W-1:0] n;
    logic [127:0]     data;
    logic [95:0]      iv;
    logic [31:0]      ctr;
    logic [127:0]     len;
  } cmd_t;

  typedef struct packed {
    logic [127:0]     data;
    logic [CNT_W-1:0] bytes;
    logic             is_tag;
    logic             last;
  } res_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last_rnd);
    logic [7:0]   b [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, all;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[i+4*c] = SBOX[b[i+4*((c+i)&3)]];
    if (!last_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    return o;
  endfunction

  // eight bits of the GF(2^128) product, most significant first
  function automatic logic [255:0] gf_step8(input logic [127:0] z_in, input logic [127:0] v_in,
                                            input logic [7:0] a8);
    logic [127:0] z, v;
    logic         lsb;
    z = z_in;
    v = v_in;
    for (int k = 0; k < 8; k++) begin
      if (a8[7-k]) z = z ^ v;
      lsb = v[0];
      v = v >> 1;
      if (lsb) v[127:120] = v[127:120] ^ GF_POLY;
    end
    return {z, v};
  endfunction

  function automatic logic [127:0] lead_mask(input logic [CNT_W-1:0] n);
    return ~({128{1'b1}} >> {n, 3'b000});
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/gcm_queue.sv
// Short command queue between the front and back ends.
// Depends on gcm_pkg for the command record.
`default_nettype none
module gcm_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gcm_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output gcm_pkg::cmd_t head_o
);
  import gcm_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/gcm_front.sv
// Front end: accepts input blocks, classifies them and builds commands.
// Holds the IV, the counter and the length counts. Depends on gcm_pkg.
`default_nettype none
module gcm_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gcm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gcm_pkg::CFG_DW-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [127:0]                      data_i,
  input  logic [gcm_pkg::CNT_W-1:0]         byte_count_i,
  input  logic                              last_i,
  input  logic                              back_ready_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output gcm_pkg::cmd_t                     cmd_o,
  output logic                              clr_o
);
  import gcm_pkg::*;

  logic [63:0]      iv_high_q;
  logic [31:0]      iv_low_q;
  logic [31:0]      ctr_q, ctr_d;
  logic [63:0]      aad_bits_q, aad_bits_d, text_bits_q, text_bits_d;
  logic [CNT_W-1:0] n;
  logic             nz, do_aad, do_text;
  logic [63:0]      add_bits;

  assign in_ready_o = back_ready_i && !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;
  assign clr_o      = cfg_we_i && (cfg_idx_i <= REG_IV_LOW);

  assign n        = (byte_count_i > FULL_BLOCK_BYTES) ? FULL_BLOCK_BYTES : byte_count_i;
  assign nz       = (n != '0);
  assign do_text  = func_i && nz;
  assign do_aad   = !func_i && nz && (text_bits_q == '0);
  assign add_bits = {56'd0, n, 3'b000};

  always_comb begin
    ctr_d       = do_text ? ctr_q + 32'd1 : ctr_q;
    aad_bits_d  = do_aad ? aad_bits_q + add_bits : aad_bits_q;
    text_bits_d = do_text ? text_bits_q + add_bits : text_bits_q;
    cmd_o.do_text = do_text;
    cmd_o.do_aad  = do_aad;
    cmd_o.last    = last_i;
    cmd_o.n       = n;
    cmd_o.data    = data_i & lead_mask(n);
    cmd_o.iv      = {iv_high_q, iv_low_q};
    cmd_o.ctr     = ctr_d;
    cmd_o.len     = {aad_bits_d, text_bits_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_high_q   <= '0;
      iv_low_q    <= '0;
      ctr_q       <= J0_COUNTER;
      aad_bits_q  <= '0;
      text_bits_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_IV_HIGH) iv_high_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == REG_IV_LOW)  iv_low_q  <= cfg_wdata_i[31:0];
      if (clr_o || (push_o && last_i)) begin
        ctr_q       <= J0_COUNTER;
        aad_bits_q  <= '0;
        text_bits_q <= '0;
      end else if (push_o) begin
        ctr_q       <= ctr_d;
        aad_bits_q  <= aad_bits_d;
        text_bits_q <= text_bits_d;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/gcm_keysched.sv
// Key register and sequential key expansion, one schedule word per cycle.
// Holds the round key table read by the back end. Depends on gcm_pkg.
`default_nettype none
module gcm_keysched #(
  parameter int unsigned KEY_BYTES = 32,
  localparam int unsigned NR       = KEY_BYTES / 4 + 6,
  localparam int unsigned RW       = $clog2(NR + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gcm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gcm_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  logic [RW-1:0]                 rk_idx_i,
  output logic [127:0]                  rk_o,
  output logic                          ready_o
);
  import gcm_pkg::*;

  localparam int unsigned NK     = KEY_BYTES / 4;
  localparam int unsigned NWORDS = 4 * (NR + 1);
  localparam int unsigned IW     = $clog2(NWORDS);
  localparam int unsigned JW     = $clog2(NK);

  logic [63:0]   key_q [4];
  logic [31:0]   win_q [NK];
  logic [127:0]  rk_q  [NR+1];
  logic [IW-1:0] i_q;
  logic [JW-1:0] j_q;
  logic [7:0]    rcon_q;
  logic          busy_q;
  logic [31:0]   kw [8];
  logic [31:0]   t, w;
  logic          use_rcon;
  logic          key_wr;

  assign key_wr  = cfg_we_i && (cfg_idx_i <= REG_KEY_WORD_3);
  assign ready_o = !busy_q;
  assign rk_o    = rk_q[rk_idx_i];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      kw[2*k]   = key_q[k][63:32];
      kw[2*k+1] = key_q[k][31:0];
    end
    use_rcon = 1'b0;
    t = win_q[NK-1];
    if (i_q >= IW'(NK)) begin
      if (j_q == '0) begin
        t = sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'd0};
        use_rcon = 1'b1;
      end else if (NK > 6 && j_q == JW'(4)) begin
        t = sub_word(t);
      end
      w = win_q[0] ^ t;
    end else begin
      w = kw[i_q[2:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) key_q[k] <= '0;
      busy_q <= 1'b1;
      i_q    <= '0;
      j_q    <= '0;
      rcon_q <= 8'h01;
    end else if (key_wr) begin
      key_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
      busy_q <= 1'b1;
      i_q    <= '0;
      j_q    <= '0;
      rcon_q <= 8'h01;
    end else if (busy_q) begin
      if (use_rcon) rcon_q <= xtime(rcon_q);
      j_q <= (j_q == JW'(NK - 1)) ? '0 : j_q + 1'b1;
      if (i_q == IW'(NWORDS - 1)) busy_q <= 1'b0;
      else i_q <= i_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !key_wr) begin
      for (int k = 0; k < NK - 1; k++) win_q[k] <= win_q[k+1];
      win_q[NK-1] <= w;
      if (i_q[1:0] == 2'd3) rk_q[RW'(i_q >> 2)] <= {win_q[NK-3], win_q[NK-2], win_q[NK-1], w};
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/gcm_back.sv
// Back end: iterative AES core, 8-bit-per-cycle GHASH unit and result register.
// Runs one queued command at a time. Depends on gcm_pkg.
`default_nettype none
module gcm_back #(
  parameter int unsigned KEY_BYTES = 32,
  localparam int unsigned NR       = KEY_BYTES / 4 + 6,
  localparam int unsigned RW       = $clog2(NR + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ks_ready_i,
  output logic [RW-1:0] rk_idx_o,
  input  logic [127:0]  rk_i,
  input  logic          clr_i,
  output logic          ready_o,
  input  logic          q_valid_i,
  input  gcm_pkg::cmd_t q_head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gcm_pkg::res_t out_o
);
  import gcm_pkg::*;

  back_state_e  state_q, state_d;
  cmd_t         cur_q;
  logic [127:0] h_q, acc_q, hold_q;
  logic [127:0] aes_s_q, aes_out;
  logic [RW-1:0] rnd_q;
  logic         aes_busy_q, aes_done;
  logic [127:0] gh_a_q, gh_z_q, gh_v_q;
  logic [3:0]   gh_cnt_q;
  logic         gh_busy_q, gh_done;
  logic [255:0] gh_nxt;
  res_t         res_q;
  logic         res_valid_q, out_free;

  logic         aes_start, gh_start, push, h_load, ct_load, tag_load, acc_clr;
  logic [127:0] aes_blk, gh_x;
  res_t         push_res;

  assign out_free    = !res_valid_q || out_ready_i;
  assign aes_done    = aes_busy_q && (rnd_q == RW'(NR));
  assign gh_done     = gh_busy_q && (gh_cnt_q == 4'd15);
  assign aes_out     = aes_round(aes_s_q, rnd_q == RW'(NR)) ^ rk_i;
  assign gh_nxt      = gf_step8(gh_z_q, gh_v_q, gh_a_q[127:120]);
  assign rk_idx_o    = aes_start ? '0 : rnd_q;
  assign ready_o     = ks_ready_i && state_q != ST_WAIT_KEY && state_q != ST_HASH_KEY;
  assign out_valid_o = res_valid_q;
  assign out_o       = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_WAIT_KEY: if (ks_ready_i) state_d = ST_HASH_KEY;
      ST_HASH_KEY: if (aes_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_head_i.do_text)     state_d = ST_CTR_AES;
          else if (q_head_i.do_aad) state_d = ST_GH_DATA;
          else if (q_head_i.last)   state_d = ST_LEN_PREP;
        end
      end
      ST_CTR_AES:  if (aes_done) state_d = ST_CT_OUT;
      ST_CT_OUT:   if (out_free) state_d = ST_GH_DATA;
      ST_GH_DATA:  if (gh_done) state_d = cur_q.last ? ST_LEN_PREP : ST_IDLE;
      ST_LEN_PREP: state_d = ST_GH_LEN;
      ST_GH_LEN:   if (gh_done) state_d = ST_TAG_AES;
      ST_TAG_AES:  if (aes_done) state_d = ST_TAG_OUT;
      ST_TAG_OUT:  if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_WAIT_KEY;
    endcase
    if (!ks_ready_i) state_d = ST_WAIT_KEY;
  end

  always_comb begin
    aes_start = 1'b0;
    aes_blk   = '0;
    gh_start  = 1'b0;
    gh_x      = '0;
    push      = 1'b0;
    push_res  = '0;
    pop_o     = 1'b0;
    h_load    = 1'b0;
    ct_load   = 1'b0;
    tag_load  = 1'b0;
    acc_clr   = clr_i;
    case (state_q)
      ST_WAIT_KEY: aes_start = ks_ready_i;
      ST_HASH_KEY: h_load = aes_done;
      ST_IDLE: begin
        pop_o = q_valid_i;
        if (q_valid_i && q_head_i.do_text) begin
          aes_start = 1'b1;
          aes_blk   = {q_head_i.iv, q_head_i.ctr};
        end else if (q_valid_i && q_head_i.do_aad) begin
          gh_start = 1'b1;
          gh_x     = q_head_i.data;
        end
      end
      ST_CTR_AES: ct_load = aes_done;
      ST_CT_OUT: begin
        push     = out_free;
        push_res = '{data: hold_q, bytes: cur_q.n, is_tag: 1'b0, last: 1'b0};
        gh_start = out_free;
        gh_x     = hold_q;
      end
      ST_LEN_PREP: begin
        gh_start = 1'b1;
        gh_x     = cur_q.len;
      end
      ST_GH_LEN: begin
        aes_start = gh_done;
        aes_blk   = {cur_q.iv, J0_COUNTER};
      end
      ST_TAG_AES: tag_load = aes_done;
      ST_TAG_OUT: begin
        push     = out_free;
        push_res = '{data: hold_q, bytes: FULL_BLOCK_BYTES, is_tag: 1'b1, last: 1'b1};
        acc_clr  = clr_i || out_free;
      end
      default: ;
    endcase
    if (!ks_ready_i) begin
      aes_start = 1'b0;
      gh_start  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT_KEY;
      aes_busy_q  <= 1'b0;
      rnd_q       <= '0;
      gh_busy_q   <= 1'b0;
      gh_cnt_q    <= '0;
      res_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      state_q <= state_d;
      if (!ks_ready_i) begin
        aes_busy_q <= 1'b0;
      end else if (aes_start) begin
        aes_busy_q <= 1'b1;
        rnd_q      <= RW'(1);
      end else if (aes_busy_q) begin
        if (aes_done) aes_busy_q <= 1'b0;
        else rnd_q <= rnd_q + 1'b1;
      end
      if (gh_start) begin
        gh_busy_q <= 1'b1;
        gh_cnt_q  <= '0;
      end else if (gh_busy_q) begin
        gh_cnt_q <= gh_cnt_q + 1'b1;
        if (gh_done) gh_busy_q <= 1'b0;
      end
      if (acc_clr) acc_q <= '0;
      else if (gh_done) acc_q <= gh_nxt[255:128];
      if (push) res_valid_q <= 1'b1;
      else if (out_ready_i) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (aes_start) aes_s_q <= aes_blk ^ rk_i;
    else if (aes_busy_q) aes_s_q <= aes_out;
    if (gh_start) begin
      gh_a_q <= acc_q ^ gh_x;
      gh_z_q <= '0;
      gh_v_q <= h_q;
    end else if (gh_busy_q) begin
      gh_a_q <= {gh_a_q[119:0], 8'd0};
      gh_z_q <= gh_nxt[255:128];
      gh_v_q <= gh_nxt[127:0];
    end
    if (pop_o) cur_q <= q_head_i;
    if (h_load) h_q <= aes_out;
    if (ct_load) hold_q <= (aes_out ^ cur_q.data) & lead_mask(cur_q.n);
    if (tag_load) hold_q <= aes_out ^ acc_q;
    if (push) res_q <= push_res;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/aes_gcm_encryptor_unit.sv
// AES-GCM encryptor, top level: ports, configuration decode and wiring.
// Instantiates gcm_front, gcm_queue, gcm_keysched and gcm_back; uses gcm_pkg.
//
// Encrypts and authenticates one message as a stream of 128-bit blocks. The
// front end accepts a block and queues a command; the back end runs the AES
// core (one round per cycle) and the GHASH unit (eight bits per cycle) one
// after the other at its own pace. A plaintext block goes through the AES core
// and then the GHASH unit, an AAD block through the GHASH unit only, and the
// final block adds the length block and the tag. After reset and after every
// key write the key is expanded one word per cycle and H is then computed;
// s_axis_tready stays low meanwhile.
`default_nettype none
module aes_gcm_encryptor_unit #(
  parameter int unsigned KEY_BYTES   = 32,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gcm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gcm_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [135:0]                  s_axis_tdata,  // data_high, data_low, byte_count
  input  logic                          s_axis_tuser,  // func
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [135:0]                  m_axis_tdata,  // out_high, out_low, out_bytes
  output logic                          m_axis_tuser,  // is_tag
  output logic                          m_axis_tlast
);
  import gcm_pkg::*;

  localparam int unsigned NR = KEY_BYTES / 4 + 6;
  localparam int unsigned RW = $clog2(NR + 1);

  cmd_t          cmd, head;
  res_t          res;
  logic          push, pop, q_full, q_valid, clr, back_ready, ks_ready;
  logic [RW-1:0] rk_idx;
  logic [127:0]  rk;

  gcm_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .func_i       (s_axis_tuser),
    .data_i       ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .byte_count_i (s_axis_tdata[132:128]),
    .last_i       (s_axis_tlast),
    .back_ready_i (back_ready),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (cmd),
    .clr_o        (clr)
  );

  gcm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  gcm_keysched #(.KEY_BYTES(KEY_BYTES)) u_keysched (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .rk_idx_i (rk_idx),
    .rk_o     (rk),
    .ready_o  (ks_ready)
  );

  gcm_back #(.KEY_BYTES(KEY_BYTES)) u_back (
    .clk_i, .rst_ni,
    .ks_ready_i  (ks_ready),
    .rk_idx_o    (rk_idx),
    .rk_i        (rk),
    .clr_i       (clr),
    .ready_o     (back_ready),
    .q_valid_i   (q_valid),
    .q_head_i    (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {3'b000, res.bytes, res.data[63:0], res.data[127:64]};
  assign m_axis_tuser = res.is_tag;
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

FILE: hw/rtl/gcm_checker.sv
// Port-level checks for aes_gcm_encryptor_unit and the bind that attaches them.
// Sees the top-level ports only; no package dependency.
`default_nettype none
module gcm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         cfg_we_i,
  input logic [2:0]   cfg_idx_i,
  input logic [63:0]  cfg_wdata_i,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [135:0] s_axis_tdata,
  input logic         s_axis_tuser,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result transfer changed");

  a_tag_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[132:128] == 5'd16)
    else $error("tag without last or full byte count");

  a_ct_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      !m_axis_tlast && m_axis_tdata[132:128] != 5'd0 && m_axis_tdata[132:128] <= 5'd16)
    else $error("bad ciphertext result");

  a_rekey_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i <= 3'd3 |=> !s_axis_tready)
    else $error("input taken during key expansion");

endmodule

bind aes_gcm_encryptor_unit gcm_checker u_gcm_checker (.*);
`default_nettype wire

FILE: tb/sv/gcm_checker.sv
`timescale 1ns / 1ps
// Stream checker for the AES-GCM encryptor: tracks configuration writes and input
// transfers, predicts ciphertext and tags, and compares them with the output transfers.
// Depends on gcm_pkg for register indexes, the S-box table and the field widths.
module gcm_scoreboard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gcm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gcm_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  logic                          s_valid_i,
  input  logic                          s_ready_i,
  input  logic [135:0]                  s_data_i,
  input  logic                          s_user_i,
  input  logic                          s_last_i,
  input  logic                          m_valid_i,
  input  logic                          m_ready_i,
  input  logic [135:0]                  m_data_i,
  input  logic                          m_user_i,
  input  logic                          m_last_i,
  output int                            errors_o,
  output int                            pending_o
);
  import gcm_pkg::*;

  localparam int ROUNDS = 14;

  typedef struct {
    logic [127:0]     blk;
    logic [CNT_W-1:0] bytes;
    logic             tag;
    logic             fin;
  } cipher_out_t;

  logic [63:0]  key_w [4];
  logic [63:0]  iv_hi;
  logic [31:0]  iv_lo;
  logic [127:0] rkey [ROUNDS+1];
  logic [127:0] hkey;
  logic [127:0] acc;
  logic [31:0]  ctr;
  logic [63:0]  aad_bits;
  logic [63:0]  txt_bits;
  cipher_out_t  cipher_q [$];

  function automatic logic [7:0] dbl(input logic [7:0] b);
    return b[7] ? ((b << 1) ^ 8'h1b) : (b << 1);
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input bit fin);
    logic [7:0]   sb [16];
    logic [7:0]   sh [16];
    logic [7:0]   a0, a1, a2, a3;
    logic [127:0] o;
    for (int j = 0; j < 16; j++) sb[j] = SBOX[s[127-8*j -: 8]];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) sh[r+4*c] = sb[r + 4*((c+r) % 4)];
    for (int c = 0; c < 4; c++) begin
      a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
      if (!fin) begin
        sh[4*c]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
        sh[4*c+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
        sh[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
        sh[4*c+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
      end
    end
    for (int j = 0; j < 16; j++) o[127-8*j -: 8] = sh[j];
    return o;
  endfunction

  function automatic logic [127:0] cipher(input logic [127:0] pt);
    logic [127:0] s;
    s = pt ^ rkey[0];
    for (int r = 1; r <= ROUNDS; r++) s = enc_round(s, r == ROUNDS) ^ rkey[r];
    return s;
  endfunction

  function automatic logic [31:0] subw(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  task automatic expand_key();
    logic [31:0]  w [60];
    logic [31:0]  t;
    logic [7:0]   rc;
    logic [255:0] k;
    k = {key_w[0], key_w[1], key_w[2], key_w[3]};
    rc = 8'h01;
    for (int i = 0; i < 8; i++) w[i] = k[255-32*i -: 32];
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = dbl(rc);
      end else if (i % 8 == 4) begin
        t = subw(t);
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r <= ROUNDS; r++) rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    hkey = cipher('0);
  endtask

  function automatic logic [127:0] gf_mul(input logic [127:0] x, input logic [127:0] y);
    logic [127:0] z, v;
    z = '0;
    v = y;
    for (int i = 0; i < 128; i++) begin
      if (x[127-i]) z ^= v;
      v = v[0] ? ((v >> 1) ^ {GF_POLY, 120'h0}) : (v >> 1);
    end
    return z;
  endfunction

  task automatic absorb(input logic [127:0] x);
    acc = gf_mul(acc ^ x, hkey);
  endtask

  task automatic clear_message();
    acc = '0;
    ctr = J0_COUNTER;
    aad_bits = '0;
    txt_bits = '0;
  endtask

  task automatic encrypt_block(input logic is_text, input logic [127:0] blk,
                               input logic [CNT_W-1:0] cnt, input logic fin);
    logic [CNT_W-1:0] n;
    logic [127:0]     mask, ct;
    cipher_out_t      r;
    n = (cnt > FULL_BLOCK_BYTES) ? FULL_BLOCK_BYTES : cnt;
    mask = '0;
    for (int j = 0; j < 16; j++) if (j < n) mask[127-8*j -: 8] = 8'hff;
    if (n != 0) begin
      if (!is_text) begin
        if (txt_bits == 0) begin
          absorb(blk & mask);
          aad_bits += 64'(n) * 8;
        end
      end else begin
        ctr += 1;
        ct = (cipher({iv_hi, iv_lo, ctr}) ^ blk) & mask;
        absorb(ct);
        txt_bits += 64'(n) * 8;
        r = '{ct, n, 1'b0, 1'b0};
        cipher_q.insert(cipher_q.size(), r);
      end
    end
    if (fin) begin
      absorb({aad_bits, txt_bits});
      r = '{cipher({iv_hi, iv_lo, J0_COUNTER}) ^ acc, FULL_BLOCK_BYTES, 1'b1, 1'b1};
      cipher_q.insert(cipher_q.size(), r);
      clear_message();
    end
  endtask

  task automatic mismatch(input string what, input logic [127:0] exp_v,
                          input logic [127:0] act_v);
    if (errors_o < 10) $display("mismatch %s: expected %h got %h", what, exp_v, act_v);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_out_t e;
    logic [127:0] got;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_w[i] = '0;
      iv_hi = '0;
      iv_lo = '0;
      expand_key();
      clear_message();
      cipher_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i <= REG_KEY_WORD_3) begin
          key_w[cfg_idx_i - REG_KEY_WORD_0] = cfg_wdata_i;
          expand_key();
          clear_message();
        end else if (cfg_idx_i == REG_IV_HIGH) begin
          iv_hi = cfg_wdata_i;
          clear_message();
        end else if (cfg_idx_i == REG_IV_LOW) begin
          iv_lo = cfg_wdata_i[31:0];
          clear_message();
        end
      end
      if (s_valid_i && s_ready_i)
        encrypt_block(s_user_i, {s_data_i[63:0], s_data_i[127:64]}, s_data_i[132:128],
                      s_last_i);
      if (m_valid_i && m_ready_i) begin
        got = {m_data_i[63:0], m_data_i[127:64]};
        if (cipher_q.size() == 0) begin
          mismatch("unexpected transfer", '0, got);
        end else begin
          e = cipher_q.pop_front();
          if (got != e.blk) mismatch("data", e.blk, got);
          if (m_data_i[132:128] != e.bytes)
            mismatch("bytes", 128'(e.bytes), 128'(m_data_i[132:128]));
          if (m_user_i != e.tag) mismatch("is_tag", 128'(e.tag), 128'(m_user_i));
          if (m_last_i != e.fin) mismatch("last", 128'(e.fin), 128'(m_last_i));
        end
      end
      pending_o = cipher_q.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the AES-GCM encryptor testbench: clock, reset, configuration phases,
// directed and random message stimulus, output back-pressure and the verdict.
// Depends on gcm_pkg, aes_gcm_encryptor_unit and gcm_scoreboard.
module testbench;
  import gcm_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 150;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DW-1:0]    cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [135:0]         s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [135:0]         m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  int                   errors;
  int                   pending;
  int                   cycles = 0;
  int                   items_sent = 0;
  bit                   quiet = 1'b0;
  bit                   hold_req = 1'b0;

  aes_gcm_encryptor_unit u_dut (.*);

  gcm_scoreboard u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .s_user_i(s_axis_tuser), .s_last_i(s_axis_tlast),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .m_user_i(m_axis_tuser), .m_last_i(m_axis_tlast),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[aes_gcm_encryptor_unit] ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    if (quiet) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
  endfunction

  // back-pressure on the result side, with one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 400;
      end else if (stall == 0 && !quiet && $urandom_range(0, 49) == 0) begin
        stall = $urandom_range(10, 60);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send(input logic func, input logic [63:0] dh, input logic [63:0] dl,
                      input logic [4:0] cnt, input logic fin);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, cnt, dl, dh};
    s_axis_tuser  <= func;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic configure(input int ph);
    logic [63:0] v;
    drain();
    for (int i = 0; i <= REG_IV_LOW; i++) begin
      v = (ph == 1) ? '1 : (ph == 2) ? '0 : rnd64();
      write_reg(CFG_IDX_W'(i), v);
    end
    if (ph == 3) begin
      write_reg(CFG_IDX_W'(REG_IV_LOW + 1), rnd64());
      write_reg(CFG_IDX_W'(REG_IV_LOW + 2), rnd64());
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic message(input bit tidy, input bit close);
    int na, nt, total;
    logic [4:0] c;
    if (tidy) begin
      na = $urandom_range(0, 3);
      nt = $urandom_range(0, 6);
      total = na + nt;
      if (total == 0) begin
        send(1'($urandom_range(0, 1)), rnd64(), rnd64(), 5'd0, close);
        return;
      end
      for (int i = 0; i < total; i++) begin
        c = (i == na - 1 || i == total - 1) ? 5'($urandom_range(1, 16)) : FULL_BLOCK_BYTES;
        send(i >= na, rnd64(), rnd64(), c, close && i == total - 1);
      end
    end else begin
      total = $urandom_range(1, 6);
      for (int i = 0; i < total; i++)
        send(1'($urandom_range(0, 1)), rnd64(), rnd64(), 5'($urandom_range(0, 31)),
             close && i == total - 1);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    quiet = 1'b1;
    send(1'b0, '1, '1, FULL_BLOCK_BYTES, 1'b0);
    send(1'b0, '1, '1, 5'd0, 1'b0);
    send(1'b0, '1, '0, 5'd9, 1'b0);
    send(1'b1, '0, '0, FULL_BLOCK_BYTES, 1'b0);
    send(1'b1, '1, '1, 5'd1, 1'b0);
    send(1'b1, rnd64(), rnd64(), 5'd31, 1'b0);
    send(1'b1, rnd64(), rnd64(), 5'd0, 1'b0);
    send(1'b0, '1, '1, FULL_BLOCK_BYTES, 1'b0);
    send(1'b1, rnd64(), rnd64(), 5'd15, 1'b1);
    send(1'b0, '0, '0, 5'd0, 1'b1);
    send(1'b1, '0, '0, 5'd0, 1'b1);
    send(1'b0, '1, '1, 5'd8, 1'b1);
    send(1'b1, '1, '1, FULL_BLOCK_BYTES, 1'b1);
    send(1'b0, rnd64(), rnd64(), 5'd17, 1'b0);
    send(1'b1, rnd64(), rnd64(), 5'd7, 1'b0);
    send(1'b0, rnd64(), rnd64(), 5'd3, 1'b1);
    quiet = 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) configure(ph);
      while (items_sent < (ph + 1) * PHASE_ITEMS) begin
        quiet = ($urandom_range(0, 7) == 0);
        if (ph == 2 && items_sent >= 3 * PHASE_ITEMS - 60 && items_sent < 3 * PHASE_ITEMS - 50)
          drain();
        if (ph == 3 && items_sent >= 4 * PHASE_ITEMS - 80 && items_sent < 4 * PHASE_ITEMS - 70)
          hold_req = 1'b1;
        message($urandom_range(0, 99) < 85, 1'b1);
      end
      // leave a message open so the next register write abandons it
      if (ph == 4) message(1'b1, 1'b0);
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("[aes_gcm_encryptor_unit] OK");
    end else begin
      $display("[aes_gcm_encryptor_unit] ERROR");
    end
    $finish;
  end

endmodule
